// File: design/led_pixel_spi_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// led pixel spi encoder assertion macros
// shared assertion forms for the encoder modules
// ----------------------------------------------------------------------------
`ifndef LED_PIXEL_SPI_ENCODER_CORE_ASSERT_SVH
`define LED_PIXEL_SPI_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LPSE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpse check failed");

// next-cycle implication, sampled on clk, off while in reset
`define LPSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpse check failed");

`endif

// File: design/lpse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse package
// shared types, constants and the scaling helper of the pixel encoder
// ----------------------------------------------------------------------------
package lpse_pkg;

    localparam int BITS_PER_PIXEL   = 24;
    localparam int BYTES_PER_SYMBOL = 3;
    localparam int RESET_BYTES      = 120;
    localparam int RESET_WORDS      = RESET_BYTES / BYTES_PER_SYMBOL;
    localparam int CNT_W            = $clog2(RESET_WORDS);
    localparam int JOB_FIFO_DEPTH   = 2;

    localparam logic [23:0] SYM_ONE_WORD  = 24'hF8F8F8;
    localparam logic [23:0] SYM_ZERO_WORD = 24'h808080;

    // apb register map
    localparam int          APB_ADDR_W          = 2;
    localparam logic [1:0]  REG_BRIGHTNESS_ADDR = 2'd0;
    localparam logic [7:0]  BRIGHTNESS_RESET    = 8'd255;

    // one scaled pixel handed from front to back
    typedef struct packed {
        logic [23:0] grb;
        logic        last;
    } job_t;

    // floor(p / 255) for any p below 65280 (so any 8-bit by 8-bit product), by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = 17'(p) + 17'(p[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: design/lpse_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse stream interfaces
// pixel request channel and spi word request channel
// ----------------------------------------------------------------------------
interface lpse_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lpse_word_if;
    logic        valid;
    logic        ready;
    logic [23:0] spi_word;
    logic        is_reset;
    logic        frame_end;

    modport source (output valid, output spi_word, output is_reset, output frame_end,
                    input ready);
    modport sink   (input valid, input spi_word, input is_reset, input frame_end,
                    output ready);
endinterface

// File: design/led_pixel_spi_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led pixel spi encoder core
// turns rgb pixels into ws2812-style spi symbol words with a frame reset pulse
// ----------------------------------------------------------------------------
// each pixel request is scaled by the brightness register (floor(c*b/255)),
// packed green-red-blue and sent msb first as 24 spi words, one per cycle:
// while the word output is ready: 0xf8f8f8 for a one bit and 0x808080 for
// a zero bit. the last pixel of a frame of PIXELS pixels is followed by 40
// zero words (120 spi bytes of low reset pulse) flagged is_reset, the final
// one also flagged frame_end. throughput is set by the back-end serialiser,
// which emits one word per cycle unless the word output stalls it; a pixel
// holds it for its 24 words, the last pixel of a frame also for the reset
// pulse. the front end scales with a registered multiply, then a divide by
// 255 with a reciprocal, and a two-entry queue lets it take the next pixels
// while the serialiser is still busy, so a steady pixel stream keeps the
// output valid every cycle. with an idle queue the first word request is
// offered after the pixel request passes the product register, the queue,
// the serialiser load and the output register. brightness is written over
// apb at byte address 0 and must only change while the block is idle.
// ----------------------------------------------------------------------------
module led_pixel_spi_encoder_core #(
    parameter int PIXELS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // pixel requests in, spi word requests out
    lpse_pix_if.sink                        pix,
    lpse_word_if.source                     word
);
    import lpse_pkg::*;

    logic [7:0] brightness_reg;
    logic       cfg_write;
    job_t       front_job;
    logic       front_valid;
    logic       front_ready;
    job_t       back_job;
    logic       back_valid;
    logic       back_ready;

    // ------------------------------------------------------------------------
    // configuration: one register, writes elsewhere are dropped
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            brightness_reg <= BRIGHTNESS_RESET;
        end else if (cfg_write && (paddr == REG_BRIGHTNESS_ADDR)) begin
            brightness_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == REG_BRIGHTNESS_ADDR) ? {24'd0, brightness_reg} : 32'd0;

    // ------------------------------------------------------------------------
    // front end: accept, scale, mark the last pixel of the frame
    // ------------------------------------------------------------------------
    lpse_front #(
        .PIXELS (PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .brightness (brightness_reg),
        .pix        (pix),
        .job        (front_job),
        .job_valid  (front_valid),
        .job_ready  (front_ready)
    );

    // ------------------------------------------------------------------------
    // queue decoupling the two halves
    // ------------------------------------------------------------------------
    lpse_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (front_job),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_job   (back_job),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    // ------------------------------------------------------------------------
    // back end: bit serialiser and reset pulse generator
    // ------------------------------------------------------------------------
    lpse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .word      (word)
    );

endmodule

// File: design/lpse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse front end
// accepts pixels, scales channels, tracks frame position
// ----------------------------------------------------------------------------
module lpse_front #(
    parameter int PIXELS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     brightness,
    lpse_pix_if.sink       pix,
    output lpse_pkg::job_t job,
    output logic           job_valid,
    input  logic           job_ready
);
    import lpse_pkg::*;

    localparam int POS_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PIXELS - 1);

    logic [POS_W-1:0] pos_reg;
    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [15:0]      prod_r_reg;
    logic [15:0]      prod_g_reg;
    logic [15:0]      prod_b_reg;
    logic             accept;
    logic             is_last;

    assign pix.ready = !s1_valid_reg || job_ready;
    assign accept    = pix.valid && pix.ready;
    // out of range counts as last too
    assign is_last   = (pos_reg >= POS_LAST);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            prod_r_reg   <= '0;
            prod_g_reg   <= '0;
            prod_b_reg   <= '0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            s1_last_reg  <= is_last;
            prod_r_reg   <= 16'(pix.red)   * 16'(brightness);
            prod_g_reg   <= 16'(pix.green) * 16'(brightness);
            prod_b_reg   <= 16'(pix.blue)  * 16'(brightness);
            pos_reg      <= is_last ? '0 : pos_reg + POS_W'(1);
        end else if (job_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // grb packing after the divide by full scale
    assign job_valid = s1_valid_reg;
    assign job.grb   = {div255(prod_g_reg), div255(prod_r_reg), div255(prod_b_reg)};
    assign job.last  = s1_last_reg;

endmodule

// File: design/lpse_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse job queue
// short queue between front and back ends
// ----------------------------------------------------------------------------
`include "led_pixel_spi_encoder_core_assert.svh"

module lpse_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  lpse_pkg::job_t in_job,
    input  logic           in_valid,
    output logic           in_ready,
    output lpse_pkg::job_t out_job,
    output logic           out_valid,
    input  logic           out_ready
);
    import lpse_pkg::*;

    localparam int PTR_W = $clog2(JOB_FIFO_DEPTH);
    localparam int CNT_FW = $clog2(JOB_FIFO_DEPTH + 1);
    localparam logic [CNT_FW-1:0] FULL = CNT_FW'(JOB_FIFO_DEPTH);

    job_t              mem_reg [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_FW-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_FW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_FW'(1);
            end
        end
    end

    `LPSE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FULL)
    `LPSE_ASSERT_NEXT(a_fill_step, push && !pop, count_reg == $past(count_reg) + CNT_FW'(1))
    `LPSE_ASSERT_NEXT(a_drain_step, pop && !push, count_reg == $past(count_reg) - CNT_FW'(1))

endmodule

// File: design/lpse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse back end
// serialises a pixel into spi words and appends the frame reset pulse
// ----------------------------------------------------------------------------
`include "led_pixel_spi_encoder_core_assert.svh"

module lpse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  lpse_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_ready,
    lpse_word_if.source    word
);
    import lpse_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_RESET
    } state_t;

    localparam logic [CNT_W-1:0] DATA_LAST  = CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0] RESET_LAST = CNT_W'(RESET_WORDS - 1);

    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [23:0]       shift_reg,     shift_next;
    logic              last_reg,      last_next;
    logic              out_valid_reg, out_valid_next;
    logic [23:0]       spi_word_reg,  spi_word_next;
    logic              is_reset_reg,  is_reset_next;
    logic              frame_end_reg, frame_end_next;
    logic              can_emit;
    logic              finishing;
    logic              load;

    assign can_emit  = !out_valid_reg || word.ready;
    assign finishing = ((state_reg == ST_DATA) && (cnt_reg == DATA_LAST) && !last_reg)
                    || ((state_reg == ST_RESET) && (cnt_reg == RESET_LAST));
    assign load      = job_valid && ((state_reg == ST_IDLE) || (can_emit && finishing));
    assign job_ready = load;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !word.ready;
        spi_word_next  = spi_word_reg;
        is_reset_next  = is_reset_reg;
        frame_end_next = frame_end_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_DATA: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    spi_word_next  = shift_reg[23] ? SYM_ONE_WORD : SYM_ZERO_WORD;
                    is_reset_next  = 1'b0;
                    frame_end_next = 1'b0;
                    shift_next     = {shift_reg[22:0], 1'b0};
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (cnt_reg == DATA_LAST) begin
                        cnt_next   = '0;
                        state_next = last_reg ? ST_RESET : ST_IDLE;
                    end
                end
            end
            ST_RESET: begin
                if (can_emit) begin
                    out_valid_next = 1'b1;
                    spi_word_next  = '0;
                    is_reset_next  = 1'b1;
                    frame_end_next = (cnt_reg == RESET_LAST);
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (cnt_reg == RESET_LAST) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // next pixel picked up in the same cycle as the final word, or in the idle state
        if (load) begin
            state_next = ST_DATA;
            shift_next = job.grb;
            last_next  = job.last;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            spi_word_reg  <= '0;
            is_reset_reg  <= 1'b0;
            frame_end_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            shift_reg     <= shift_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            spi_word_reg  <= spi_word_next;
            is_reset_reg  <= is_reset_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign word.valid     = out_valid_reg;
    assign word.spi_word  = spi_word_reg;
    assign word.is_reset  = is_reset_reg;
    assign word.frame_end = frame_end_reg;

    `LPSE_ASSERT_SAME(a_end_in_pulse, out_valid_reg && frame_end_reg, is_reset_reg)
    `LPSE_ASSERT_SAME(a_pulse_low, out_valid_reg && is_reset_reg, spi_word_reg == '0)
    `LPSE_ASSERT_SAME(a_pulse_after_last, state_reg == ST_RESET, last_reg)

endmodule
